// File: sv/alr_pkg.sv
package alr_pkg;

  localparam int MaxPoints  = 256;
  localparam int MaxSamples = 64;
  localparam int PtIdxW     = 8;
  localparam int CntW       = 9;
  localparam int LenW       = 34;

  localparam logic CfgSampleCount = 1'b0;
  localparam logic CfgClosedLoop  = 1'b1;

  typedef struct packed {
    logic signed [23:0] px;
    logic signed [23:0] py;
    logic signed [23:0] pz;
    logic               final_point;
  } in_req_t;

  typedef struct packed {
    logic signed [23:0] sx;
    logic signed [23:0] sy;
    logic signed [23:0] sz;
    logic [16:0]        param_t;
    logic [7:0]         seg_from;
    logic [7:0]         seg_to;
    logic [16:0]        blend;
    logic               too_short;
    logic               final_sample;
  } out_req_t;

  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [33:0] den;
  } div_cmd_t;

endpackage

// File: sv/alr_divider.sv
// restoring divider, one quotient bit a cycle, 64-bit dividend
module alr_divider (
  input  logic              clk,
  input  logic              rst_n,
  input  alr_pkg::div_cmd_t cmd,
  output logic              busy,
  output logic [63:0]       quot
);

  logic [63:0] q_r;
  logic [34:0] rem_r;
  logic [33:0] den_r;
  logic [6:0]  cnt_r;
  logic [34:0] trial;
  logic [34:0] sub;

  assign trial = {rem_r[33:0], q_r[63]};
  assign sub   = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.start) begin
      q_r   <= cmd.num;
      rem_r <= '0;
      den_r <= cmd.den;
      cnt_r <= 7'd64;
    end else if (cnt_r != 7'd0) begin
      if (!sub[34]) begin
        rem_r <= sub;
        q_r   <= {q_r[62:0], 1'b1};
      end else begin
        rem_r <= trial;
        q_r   <= {q_r[62:0], 1'b0};
      end
      cnt_r <= cnt_r - 7'd1;
    end
  end

  assign busy = (cnt_r != 7'd0);
  assign quot = q_r;

endmodule

// File: sv/arc_length_path_resampler_unit.sv
// a point is taken while loading; a final point that leaves fewer than two points gives
// one too_short sample, else it starts a run that measures each segment (isqrt, 2 bits
// a cycle), then for each sample runs two divisions on the shared divider, three when
// the blend needs its division, walks segments, reads memories, does the lerp and waits
// out any output stall; one request at a time; no request is taken during a run
// reset: point count, configuration, state and output valid clear; memories and datapath registers are not cleared
module arc_length_path_resampler_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  alr_pkg::in_req_t   in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output alr_pkg::out_req_t  out_data,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [6:0]         cfg_wdata
);

  typedef enum logic [4:0] {
    S_LOAD, S_SEG_RD0, S_SEG_RD1, S_SQ, S_SQRT, S_ACC,
    S_SMP_D, S_SMP_DW, S_SMP_T, S_SMP_TW, S_WALK_RD, S_WALK,
    S_LEN_RD, S_LEN, S_BL_W, S_PT_RD0, S_PT_RD1, S_LERP, S_EMIT
  } state_t;

  state_t      state_r;

  logic [6:0]  sample_count_r;
  logic        closed_loop_r;
  logic [8:0]  n_r;
  logic [8:0]  nseg_r;
  logic [6:0]  count_r;
  logic [6:0]  denom_r;
  logic [6:0]  k_r;
  logic [7:0]  seg_r;
  logic [7:0]  i_r;
  logic [33:0] acc_r;
  logic [33:0] total_r;
  logic [33:0] d_r;
  logic [33:0] c0_r;
  logic [33:0] c1_r;
  logic [16:0] t_r;
  logic [16:0] blend_r;
  logic signed [23:0] a_r [3];
  logic signed [23:0] b_r [3];
  logic signed [24:0] df_r [3];
  logic [49:0] rem_r;
  logic [24:0] res_r;
  logic [4:0]  it_r;
  alr_pkg::out_req_t out_r;
  logic        out_valid_r;
  logic        bl_go_r;

  // point memory and cumulative length memory
  logic [71:0] pmem [alr_pkg::MaxPoints];
  logic [33:0] cmem [alr_pkg::MaxPoints + 1];
  logic [71:0] prd_r;
  logic [33:0] crd_r;
  logic        pwe;
  logic [7:0]  pwa;
  logic [7:0]  pra;
  logic        cwe;
  logic [8:0]  cwa;
  logic [8:0]  cra;
  logic [33:0] cwd;

  always_ff @(posedge clk) begin
    if (pwe) pmem[pwa] <= {in_data.px, in_data.py, in_data.pz};
    prd_r <= pmem[pra];
    if (cwe) cmem[cwa] <= cwd;
    crd_r <= cmem[cra];
  end

  alr_pkg::div_cmd_t div_cmd;
  logic        div_busy;
  logic [63:0] div_q;

  alr_divider u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .cmd  (div_cmd),
    .busy (div_busy),
    .quot (div_q)
  );

  assign in_ready  = (state_r == S_LOAD) && !out_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  // isqrt step: 2 bits per cycle
  logic [49:0] trial;
  assign trial = {23'd0, res_r, 2'b01} << (6'd2 * it_r);

  // sample index times total length
  logic [40:0] kt_prod;
  assign kt_prod = 41'(k_r) * 41'(total_r);

  // lerp products
  logic signed [42:0] prod [3];
  logic signed [23:0] lerp [3];
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      prod[a] = 43'(df_r[a]) * $signed({26'd0, blend_r}) + 43'sd32768;
      lerp[a] = a_r[a] + 24'(prod[a] >>> 16);
    end
  end

  logic [8:0] seg_next;
  assign seg_next = {1'b0, seg_r} + 9'd1;
  logic [7:0] b_idx;
  assign b_idx = (seg_next < n_r) ? seg_next[7:0] : 8'd0;

  always_comb begin
    pwe = in_acc && !n_r[8];
    pwa = n_r[7:0];
    pra = '0;
    cwe = 1'b0;
    cwa = '0;
    cwd = acc_r;
    cra = '0;
    div_cmd = '0;
    case (state_r)
      S_SEG_RD0: pra = i_r;
      S_SEG_RD1: pra = ({1'b0, i_r} + 9'd1 < n_r) ? i_r + 8'd1 : 8'd0;
      S_WALK_RD: cra = {1'b0, seg_r} + 9'd1;
      S_LEN_RD:  cra = {1'b0, seg_r};
      S_LEN:     cra = {1'b0, seg_r} + 9'd1;
      S_PT_RD0:  pra = seg_r;
      S_PT_RD1:  pra = b_idx;
      S_ACC: begin
        cwe = 1'b1;
        cwa = {1'b0, i_r} + 9'd1;
        cwd = acc_r + {9'd0, res_r};
      end
      S_SMP_D: begin
        div_cmd.start = 1'b1;
        div_cmd.num   = {23'd0, kt_prod};
        div_cmd.den   = 34'(denom_r);
      end
      S_SMP_T: begin
        div_cmd.start = 1'b1;
        div_cmd.num   = {41'd0, k_r, 16'd0};
        div_cmd.den   = 34'(denom_r);
      end
      S_BL_W: begin
        div_cmd.start = !bl_go_r && (c1_r != c0_r) && (d_r > c0_r);
        div_cmd.num   = {14'd0, d_r - c0_r, 16'd0};
        div_cmd.den   = c1_r - c0_r;
      end
      default: ;
    endcase
    if (state_r == S_LOAD && in_acc && in_data.final_point
        && ((n_r[8] ? n_r : n_r + 9'd1) >= 9'd2)) begin
      cwe = 1'b1;
      cwa = '0;
      cwd = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_LOAD;
      sample_count_r <= 7'd2;
      closed_loop_r  <= 1'b0;
      n_r            <= '0;
      out_valid_r    <= 1'b0;
      bl_go_r        <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == alr_pkg::CfgSampleCount) sample_count_r <= cfg_wdata;
        else closed_loop_r <= cfg_wdata[0];
      end
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      case (state_r)
        S_LOAD: if (in_acc) begin
          logic [8:0] nn;
          nn = n_r[8] ? n_r : n_r + 9'd1;
          if (!in_data.final_point) begin
            n_r <= nn;
          end else if (nn < 9'd2) begin
            out_r       <= alr_pkg::out_req_t'{too_short: 1'b1, final_sample: 1'b1,
                                               default: '0};
            out_valid_r <= 1'b1;
            n_r         <= '0;
          end else begin
            n_r     <= nn;
            count_r <= (sample_count_r < 7'd2) ? 7'd2 :
                       (sample_count_r > 7'(alr_pkg::MaxSamples)) ?
                       7'(alr_pkg::MaxSamples) : sample_count_r;
            nseg_r  <= closed_loop_r ? nn : nn - 9'd1;
            i_r     <= '0;
            acc_r   <= '0;
            state_r <= S_SEG_RD0;
          end
        end
        S_SEG_RD0: state_r <= S_SEG_RD1;
        S_SEG_RD1: begin
          {a_r[0], a_r[1], a_r[2]} <= prd_r;
          state_r <= S_SQ;
        end
        S_SQ: begin
          logic signed [24:0] dx, dy, dz;
          logic [23:0] ax, ay, az;
          logic [47:0] mx, my, mz;
          dx = 25'(signed'(prd_r[71:48])) - 25'(a_r[0]);
          dy = 25'(signed'(prd_r[47:24])) - 25'(a_r[1]);
          dz = 25'(signed'(prd_r[23:0]))  - 25'(a_r[2]);
          // squares of magnitudes keep the multipliers at 24 bits
          ax = dx[24] ? 24'(-dx) : dx[23:0];
          ay = dy[24] ? 24'(-dy) : dy[23:0];
          az = dz[24] ? 24'(-dz) : dz[23:0];
          mx = ax * ax;
          my = ay * ay;
          mz = az * az;
          rem_r <= 50'(mx) + 50'(my) + 50'(mz);
          res_r <= '0;
          it_r  <= 5'd24;
          state_r <= S_SQRT;
        end
        S_SQRT: begin
          if (rem_r >= trial) begin
            rem_r <= rem_r - trial;
            res_r <= {res_r[23:0], 1'b1};
          end else begin
            res_r <= {res_r[23:0], 1'b0};
          end
          if (it_r == 5'd0) state_r <= S_ACC;
          else it_r <= it_r - 5'd1;
        end
        S_ACC: begin
          acc_r <= acc_r + {9'd0, res_r};
          if ({1'b0, i_r} + 9'd1 == nseg_r) begin
            total_r <= acc_r + {9'd0, res_r};
            denom_r <= closed_loop_r ? count_r : count_r - 7'd1;
            k_r     <= '0;
            seg_r   <= '0;
            state_r <= S_SMP_D;
          end else begin
            i_r     <= i_r + 8'd1;
            state_r <= S_SEG_RD0;
          end
        end
        S_SMP_D: state_r <= S_SMP_DW;
        S_SMP_DW: if (!div_busy) begin
          d_r     <= div_q[33:0];
          state_r <= S_SMP_T;
        end
        S_SMP_T: state_r <= S_SMP_TW;
        S_SMP_TW: if (!div_busy) begin
          t_r     <= div_q[16:0];
          state_r <= S_WALK_RD;
        end
        S_WALK_RD: begin
          if (seg_next < nseg_r) state_r <= S_WALK;
          else state_r <= S_LEN_RD;
        end
        S_WALK: begin
          if (crd_r < d_r) begin
            seg_r   <= seg_next[7:0];
            state_r <= S_WALK_RD;
          end else begin
            state_r <= S_LEN_RD;
          end
        end
        S_LEN_RD: state_r <= S_LEN;
        S_LEN: begin
          c0_r    <= crd_r;
          state_r <= S_PT_RD0;
        end
        S_PT_RD0: begin
          c1_r    <= crd_r;
          state_r <= S_PT_RD1;
        end
        S_PT_RD1: begin
          {a_r[0], a_r[1], a_r[2]} <= prd_r;
          blend_r <= '0;
          bl_go_r <= 1'b0;
          state_r <= S_BL_W;
        end
        S_BL_W: begin
          if (!bl_go_r) begin
            {b_r[0], b_r[1], b_r[2]} <= prd_r;
            bl_go_r <= div_cmd.start;
            if (!div_cmd.start) state_r <= S_LERP;
          end else if (!div_busy) begin
            blend_r <= (div_q > 64'd65536) ? 17'd65536 : div_q[16:0];
            state_r <= S_LERP;
          end
        end
        S_LERP: begin
          for (int a = 0; a < 3; a++) df_r[a] <= 25'(b_r[a]) - 25'(a_r[a]);
          state_r <= S_EMIT;
        end
        S_EMIT: if (!out_valid_r) begin
          out_r.sx           <= lerp[0];
          out_r.sy           <= lerp[1];
          out_r.sz           <= lerp[2];
          out_r.param_t      <= t_r;
          out_r.seg_from     <= seg_r;
          out_r.seg_to       <= b_idx;
          out_r.blend        <= blend_r;
          out_r.too_short    <= 1'b0;
          out_r.final_sample <= (k_r + 7'd1 == count_r);
          out_valid_r        <= 1'b1;
          if (k_r + 7'd1 == count_r) begin
            n_r     <= '0;
            state_r <= S_LOAD;
          end else begin
            k_r     <= k_r + 7'd1;
            state_r <= S_SMP_D;
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

  a_no_in_during_run: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_LOAD) |-> !in_ready)
    else $error("request taken during a run");
  a_div_idle_on_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_cmd.start |-> !div_busy)
    else $error("divider restarted while busy");
  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> (k_r < count_r))
    else $error("sample index out of range");

endmodule
